// ===== hw/rtl/pds_pkg.sv =====
// Package for the PID drive step core: field widths, types, register
// indexes and saturation bounds. No dependencies.
package pds_pkg;

    localparam int DATA_W    = 16;               // Q8.8 data, gains, setpoint
    localparam int FRAC_BITS = 8;
    localparam int INTEG_W   = 24;               // integral, Q16.8
    localparam int LIMIT_W   = INTEG_W - 1;      // reset limit, unsigned
    localparam int ERR_W     = DATA_W + 1;       // setpoint minus measurement
    localparam int DIFF_W    = DATA_W + 2;       // error minus previous error
    localparam int SUM_W     = INTEG_W + 1;      // integral plus error
    localparam int PKP_W     = DATA_W + ERR_W;
    localparam int PKD_W     = DATA_W + DIFF_W;
    localparam int PKI_W     = DATA_W + INTEG_W;
    localparam int ACC_W     = PKI_W + 1;        // sum of the three products
    localparam int CFG_W     = LIMIT_W;          // widest register
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic        [LIMIT_W-1:0] t_limit;
    typedef logic        [CFG_W-1:0]   t_cfg_data;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KP    = 3'd0;
    localparam t_cfg_idx CFG_KI    = 3'd1;
    localparam t_cfg_idx CFG_KD    = 3'd2;
    localparam t_cfg_idx CFG_SETPT = 3'd3;
    localparam t_cfg_idx CFG_LIMIT = 3'd4;

    localparam t_limit LIMIT_RESET = LIMIT_W'(1 << (FRAC_BITS - 1));   // 0.5

    localparam t_acc   DRIVE_MAX  = ACC_W'((2 ** (DATA_W - 1)) - 1);
    localparam t_acc   DRIVE_MIN  = -DRIVE_MAX - ACC_W'(1);
    localparam t_acc   ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam t_sum   INTEG_MAX  = SUM_W'((2 ** (INTEG_W - 1)) - 1);
    localparam t_sum   INTEG_MIN  = -INTEG_MAX - SUM_W'(1);

endpackage

// ===== hw/rtl/pid_drive_step_core.sv =====
// PID drive step core: error, products and integral update, then rounding
// and drive saturation. Depends on pds_pkg.
//
//  channel   | direction | signals                                  | handshake
//  ----------+-----------+------------------------------------------+------------------------
//  in        | to core   | i_measurement                            | i_in_valid / o_in_stall
//  out       | from core | o_drive, o_drive_saturated               | o_out_valid / i_out_stall
//  cfg       | to core   | i_cfg_index, i_cfg_data                  | i_cfg_wr_en
//
// Three register stages: input, products, result. One item a cycle while the
// output does not stall; the result passes the products and result registers
// after the input transfer. The products stage sets the cycle: the error and
// difference subtracts ahead of the 16 x 18 multiply, beside the widest
// multiply (16 x 24) and the integral update. Each stage advances when the one
// after it is empty or moving, so bubbles close up under output stall. Reset
// clears the valid bits, the state and the configuration registers (limit to 0.5).
module pid_drive_step_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  pds_pkg::t_cfg_idx     i_cfg_index,
    input  pds_pkg::t_cfg_data    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pds_pkg::t_data        i_measurement,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pds_pkg::t_data        o_drive,
    output logic                  o_drive_saturated
);
    import pds_pkg::*;

    // configuration
    t_data  r_kp, r_ki, r_kd, r_setpt;
    t_limit r_limit;

    // state
    t_err   r_prev_err;
    t_integ r_integ;

    // stages
    logic   r_in_valid, r_p_valid, r_out_valid;
    t_data  r_meas;
    logic signed [PKP_W-1:0] r_pkp;
    logic signed [PKD_W-1:0] r_pkd;
    logic signed [PKI_W-1:0] r_pki;
    t_data  r_drive;
    logic   r_sat;

    logic   en_out, en_p, en_in, upd;
    t_err   w_err;
    t_diff  w_diff;
    t_sum   w_sum;
    t_integ n_integ;
    t_acc   w_acc, w_shift;
    t_data  n_drive;
    logic   n_sat;

    assign en_out     = !r_out_valid || !i_out_stall;
    assign en_p       = !r_p_valid || en_out;
    assign en_in      = !r_in_valid || en_p;
    assign upd        = r_in_valid && en_p;
    assign o_in_stall = !en_in;

    // error, difference and integral update
    always_comb begin
        w_err  = ERR_W'(r_setpt) - ERR_W'(r_meas);
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev_err);
        w_sum  = SUM_W'(r_integ) + SUM_W'(w_err);
        if (w_sum > INTEG_MAX) begin
            n_integ = INTEG_MAX[INTEG_W-1:0];
        end else if (w_sum < INTEG_MIN) begin
            n_integ = INTEG_MIN[INTEG_W-1:0];
        end else begin
            n_integ = w_sum[INTEG_W-1:0];
        end
        // clear only when strictly above the limit
        if (SUM_W'(n_integ) > $signed({2'b00, r_limit})) begin
            n_integ = '0;
        end
    end

    // sum, round half up, saturate
    always_comb begin
        w_acc   = ACC_W'(r_pkp) + ACC_W'(r_pkd) + ACC_W'(r_pki) + ROUND_HALF;
        w_shift = w_acc >>> FRAC_BITS;
        if (w_shift > DRIVE_MAX) begin
            n_drive = DRIVE_MAX[DATA_W-1:0];
            n_sat   = 1'b1;
        end else if (w_shift < DRIVE_MIN) begin
            n_drive = DRIVE_MIN[DATA_W-1:0];
            n_sat   = 1'b1;
        end else begin
            n_drive = w_shift[DATA_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_setpt <= '0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KP:    r_kp    <= i_cfg_data[DATA_W-1:0];
                CFG_KI:    r_ki    <= i_cfg_data[DATA_W-1:0];
                CFG_KD:    r_kd    <= i_cfg_data[DATA_W-1:0];
                CFG_SETPT: r_setpt <= i_cfg_data[DATA_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
            r_integ     <= '0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_in_valid;
            end
            if (en_p) begin
                r_p_valid <= r_in_valid;
            end
            if (en_out) begin
                r_out_valid <= r_p_valid;
            end
            if (upd) begin
                r_prev_err <= w_err;
                r_integ    <= n_integ;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en_in && i_in_valid) begin
            r_meas <= i_measurement;
        end
        if (upd) begin
            // integral term uses the value held from earlier items
            r_pkp <= r_kp * w_err;
            r_pkd <= r_kd * w_diff;
            r_pki <= r_ki * r_integ;
        end
        if (en_out && r_p_valid) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;
    assign o_drive_saturated = r_sat;

`ifndef SYNTH
    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_saturated |->
            (o_drive == DRIVE_MAX[DATA_W-1:0]) || (o_drive == DRIVE_MIN[DATA_W-1:0]))
        else $error("saturated drive not at a bound");

    a_integ_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (SUM_W'(r_integ) <= $signed({2'b00, $past(r_limit)})))
        else $error("integral above reset limit after update");

    a_prev_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_prev_err == $past(w_err)))
        else $error("previous error not taken from the transferred item");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_p_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== test/pid_drive_step_core_tb.sv =====
// Self-checking testbench for pid_drive_step_core: a drive predictor with its own
// copy of the gains and controller state scores every result against the DUT.
// Depends on pds_pkg and the pid_drive_step_core RTL.
package drive_check_pkg;
    import pds_pkg::*;

    typedef struct packed {
        t_data drive;
        logic  clipped;
    } t_drive_result;

    class t_drive_scoreboard;
        t_data  kp, ki, kd, setpt;
        t_limit limit;
        longint prev_error, integral;
        t_drive_result due_q[$];
        int errors;
        int results;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            setpt = '0;
            limit = LIMIT_RESET;
            prev_error = 0;
            integral = 0;
            errors = 0;
            results = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_cfg_data d);
            case (idx)
                CFG_KP:    kp = d[DATA_W-1:0];
                CFG_KI:    ki = d[DATA_W-1:0];
                CFG_KD:    kd = d[DATA_W-1:0];
                CFG_SETPT: setpt = d[DATA_W-1:0];
                CFG_LIMIT: limit = d[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int w, output bit clipped);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            clipped = 1'b0;
            if (v > hi) begin
                clipped = 1'b1;
                return hi;
            end
            if (v < lo) begin
                clipped = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // Work out the drive for one accepted measurement, then advance the state.
        function void note_measurement(t_data m);
            longint err, acc, sum;
            bit clipped, unused;
            t_drive_result r;
            err = longint'(setpt) - longint'(m);
            acc = longint'(kp) * err + longint'(kd) * (err - prev_error)
                + longint'(ki) * integral;
            // round half up, then drop the extra fraction bits
            acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            r.drive = t_data'(clamp(acc, DATA_W, clipped));
            r.clipped = clipped;
            due_q.insert(due_q.size(), r);
            prev_error = err;
            sum = clamp(integral + err, INTEG_W, unused);
            integral = (sum > longint'(limit)) ? 0 : sum;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_drive(t_data drive, logic clipped);
            t_drive_result want;
            results++;
            if (due_q.size() == 0) begin
                report($sformatf("result %0d: drive %h with no transfer pending",
                                 results, drive));
                return;
            end
            want = due_q.pop_front();
            if (drive !== want.drive)
                report($sformatf("result %0d: drive %h, predicted %h",
                                 results, drive, want.drive));
            if (clipped !== want.clipped)
                report($sformatf("result %0d: drive_saturated %b, predicted %b",
                                 results, clipped, want.clipped));
        endtask
    endclass
endpackage

module pid_drive_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;
    import drive_check_pkg::*;

    typedef enum {MEAS_NEAR, MEAS_PUSH_UP, MEAS_PUSH_DOWN} t_meas_kind;

    localparam t_cfg_idx CFG_IDX_LAST = '1;

    // Setpoint 0, kp 0.5: odd errors land on rounding ties. With the limit at
    // 1.0 the integral reaches the limit exactly, then one step past it.
    localparam t_data TIE_AND_LIMIT_SEQ [11] = '{
        16'sh0000, 16'sh0001, 16'shFFFF, 16'shFFFD, 16'sh0003, 16'shFF00,
        16'shFFFF, 16'sh0100, 16'sh8000, 16'sh7FFF, 16'sh7FFF
    };
    localparam t_data NEG_SETPT_SEQ [6] = '{
        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0000
    };
    localparam t_data POS_SETPT_SEQ [6] = '{
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0001, 16'shFF80, 16'sh7FFF
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;
    logic      i_in_valid;
    logic      o_in_stall;
    t_data     i_measurement;
    logic      o_out_valid;
    logic      i_out_stall;
    t_data     o_drive;
    logic      o_drive_saturated;

    t_drive_scoreboard sb = new();
    int idle_pct = 34;

    pid_drive_step_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_measurement    (i_measurement),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive),
        .o_drive_saturated(o_drive_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic write_reg(t_cfg_idx idx, t_cfg_data d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    // 16-bit registers ignore the upper data bits: fill them with noise.
    function automatic t_cfg_data with_noise(t_data g);
        t_cfg_data d;
        d = t_cfg_data'($urandom);
        d[DATA_W-1:0] = g;
        return d;
    endfunction

    task automatic load_controller(t_data kp, t_data ki, t_data kd, t_data sp,
                                   t_limit lim);
        write_reg(CFG_KP, with_noise(kp));
        write_reg(CFG_KI, with_noise(ki));
        write_reg(CFG_KD, with_noise(kd));
        write_reg(CFG_SETPT, with_noise(sp));
        write_reg(CFG_LIMIT, lim);
        // unmapped index: must leave every register alone
        write_reg(t_cfg_idx'($urandom_range(int'(CFG_LIMIT) + 1, int'(CFG_IDX_LAST))),
                  t_cfg_data'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic offer_measurement(t_data m);
        // insert idle cycles before the offer, each drawn with the idle chance
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measurement <= m;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_measurement(m);
    endtask

    task automatic drain_results();
        int n;
        i_in_valid <= 1'b0;
        for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge i_clk);
        // three pipeline stages: give them time to empty before touching registers
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_data pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return t_data'($urandom);
            default: return t_data'(int'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic t_limit pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return LIMIT_RESET;
            3: return t_limit'($urandom);
            default: return t_limit'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic t_data pick_measurement(t_meas_kind kind);
        case (kind)
            MEAS_PUSH_UP:
                return ($urandom_range(0, 7) != 0) ? 16'sh8000 : t_data'($urandom);
            MEAS_PUSH_DOWN:
                return ($urandom_range(0, 7) != 0) ? 16'sh7FFF : t_data'($urandom);
            default:
                case ($urandom_range(0, 7))
                    0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                    1: return t_data'($urandom);
                    default:
                        return t_data'(int'(sb.setpt) + int'($urandom_range(0, 767)) - 384);
                endcase
        endcase
    endfunction

    // Receiver: random stall, plus one long hold-off so the pipe backs up.
    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_drive(o_drive, o_drive_saturated);
            if (hold_left > 0) begin
                hold_left--;
            end else if (!held && sb.results >= 200) begin
                held = 1'b1;
                hold_left = 150;
            end
            i_out_stall <= (hold_left > 0) || ($urandom_range(99) < idle_pct);
        end
    end

    initial begin : stimulus
        t_data kp, ki, kd, sp;
        t_limit lim;
        t_meas_kind kind;
        int count;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_KP;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_measurement <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_controller(16'sh0080, 16'sh0100, 16'sh0100, 16'sh0000, t_limit'(256));
        foreach (TIE_AND_LIMIT_SEQ[i]) offer_measurement(TIE_AND_LIMIT_SEQ[i]);
        drain_results();
        load_controller(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, '0);
        foreach (NEG_SETPT_SEQ[i]) offer_measurement(NEG_SETPT_SEQ[i]);
        drain_results();
        load_controller(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, '1);
        foreach (POS_SETPT_SEQ[i]) offer_measurement(POS_SETPT_SEQ[i]);
        drain_results();

        for (int p = 0; p < 7; p++) begin
            kp = pick_gain();
            ki = pick_gain();
            kd = pick_gain();
            sp = ($urandom_range(0, 3) == 0) ? pick_gain() : t_data'($urandom);
            lim = pick_limit();
            kind = MEAS_NEAR;
            count = 30;
            idle_pct = 34;
            case (p)
                1: begin
                    idle_pct = 0;
                    count = 40;
                end
                // drive the integral into its upper clamp; the limit never clears it
                2: begin
                    kind = MEAS_PUSH_UP;
                    sp = 16'sh7FFF;
                    lim = '1;
                    count = 190;
                end
                // zero limit drops the wound-up integral before the push down
                3: lim = '0;
                4: begin
                    kind = MEAS_PUSH_DOWN;
                    sp = 16'sh8000;
                    lim = '1;
                    count = 190;
                end
                default: ;
            endcase
            load_controller(kp, ki, kd, sp, lim);
            repeat (count) offer_measurement(pick_measurement(kind));
            drain_results();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pds_pkg.sv
hw/rtl/pid_drive_step_core.sv
test/pid_drive_step_core_tb.sv
